[rtl/modbus_sensor_response_parser_macros.svh]
// assertion macros for the parser checker
`ifndef MODBUS_SENSOR_RESPONSE_PARSER_MACROS_SVH
`define MODBUS_SENSOR_RESPONSE_PARSER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MSRP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser assertion failed");

// next-cycle implication, disabled while in reset
`define MSRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser assertion failed");

`endif

[rtl/msrp_pkg.sv]
// types and constants of the modbus response parser
`timescale 1ns / 1ps

package msrp_pkg;

    localparam int unsigned POS_W = 4;

    localparam logic [POS_W-1:0] POS_ADDRESS    = 4'd0;
    localparam logic [POS_W-1:0] POS_FUNCTION   = 4'd1;
    localparam logic [POS_W-1:0] POS_COUNT      = 4'd2;
    localparam logic [POS_W-1:0] POS_DATA_FIRST = 4'd3;
    localparam logic [POS_W-1:0] POS_DATA_LAST  = 4'd6;
    localparam logic [POS_W-1:0] POS_CRC_LOW    = 4'd7;
    localparam logic [POS_W-1:0] POS_CRC_HIGH   = 4'd8;

    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_PRESET     = 16'hFFFF;
    localparam logic [7:0]  EXPECTED_COUNT = 8'h04;
    localparam logic [7:0]  RESET_DEVICE_ADDRESS = 8'h01;
    localparam logic [7:0]  RESET_FUNCTION_CODE  = 8'h03;

    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_FUNCTION_CODE  = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_HEADER = 2'd1,
        STATUS_CRC    = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] humidity;
        logic [15:0] temperature;
        status_t     status;
    } msrp_result_t;

    typedef struct packed {
        logic         last;
        msrp_result_t result;
    } msrp_engine_out_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

[rtl/msrp_frame_engine.sv]
// frame state: byte position, running crc, header check, payload capture
`timescale 1ns / 1ps

module msrp_frame_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [7:0]                rx_byte,
    input  logic                      frame_start,
    input  logic [7:0]                device_address,
    input  logic [7:0]                function_code,
    output msrp_pkg::msrp_engine_out_t eng_out
);
    import msrp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic             hok_reg, hok_next;
    logic [31:0]      pay_reg, pay_next;
    logic [7:0]       lo_reg,  lo_next;

    logic [POS_W-1:0] pos;
    logic [15:0]      crc_base;
    logic             hok;
    logic [31:0]      pay;
    logic [7:0]       lo;
    logic [15:0]      rx_crc;
    logic [15:0]      t_raw, h_raw;
    logic             last;

    always_comb
    begin
        // a start flag makes this byte the first of a fresh frame
        pos      = frame_start ? POS_ADDRESS : pos_reg;
        crc_base = frame_start ? CRC_PRESET : crc_reg;
        hok      = frame_start ? 1'b1 : hok_reg;
        pay      = frame_start ? 32'd0 : pay_reg;
        lo       = frame_start ? 8'd0 : lo_reg;

        crc_next = (pos <= POS_DATA_LAST) ? crc16_update(crc_base, rx_byte) : crc_base;
        hok_next = hok;
        pay_next = pay;
        lo_next  = lo;

        case (pos)
            POS_ADDRESS:  if (rx_byte != device_address) hok_next = 1'b0;
            POS_FUNCTION: if (rx_byte != function_code) hok_next = 1'b0;
            POS_COUNT:    if (rx_byte != EXPECTED_COUNT) hok_next = 1'b0;
            POS_CRC_LOW:  lo_next = rx_byte;
            default:
            begin
                if (pos >= POS_DATA_FIRST && pos <= POS_DATA_LAST)
                    pay_next = {pay[23:0], rx_byte};
            end
        endcase

        last   = (pos == POS_CRC_HIGH);
        rx_crc = {rx_byte, lo};

        t_raw = pay[31:16];
        h_raw = pay[15:0];

        eng_out.last                      = last;
        eng_out.result.status             = STATUS_OK;
        eng_out.result.temperature        = 16'd0;
        eng_out.result.humidity           = 16'd0;
        if (!hok)
            eng_out.result.status = STATUS_HEADER;
        else if (rx_crc != crc_base)
            eng_out.result.status = STATUS_CRC;
        else
        begin
            // times ten as shift-and-add, wraps at 16 bits
            eng_out.result.temperature = (t_raw << 3) + (t_raw << 1);
            eng_out.result.humidity    = (h_raw << 3) + (h_raw << 1);
        end

        if (last)
        begin
            pos_next = POS_ADDRESS;
            crc_next = CRC_PRESET;
            hok_next = 1'b1;
            pay_next = 32'd0;
            lo_next  = 8'd0;
        end
        else
            pos_next = pos + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_ADDRESS;
            crc_reg <= CRC_PRESET;
            hok_reg <= 1'b1;
            pay_reg <= 32'd0;
            lo_reg  <= 8'd0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            hok_reg <= hok_next;
            pay_reg <= pay_next;
            lo_reg  <= lo_next;
        end
    end

endmodule

[rtl/modbus_sensor_response_parser.sv]
// modbus rtu read-holding response parser, one byte per word
// a frame's last byte loads the result register when the output is free. throughput: one byte
// per cycle unless a last byte stalls; the crc update and header check fit between the
// input register and the frame state, result register parts the output side
// reset: asynchronous, active low; clears frame state, crc to preset, expected
// address to 1 and function code to 3
`timescale 1ns / 1ps

module modbus_sensor_response_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // rx_byte [7:0]
    input  logic                          s_tuser,   // frame_start [0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // status [1:0], temperature [17:2], humidity [33:18]
    input  logic                          cfg_we,
    input  logic [msrp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_wdata
);
    import msrp_pkg::*;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_start_reg;
    logic             out_valid_reg;
    msrp_result_t     out_data_reg;
    logic [7:0]       dev_addr_reg;
    logic [7:0]       func_code_reg;

    msrp_engine_out_t eng_out;
    logic             out_free;
    logic             consume;

    assign out_free = !out_valid_reg || m_tready;
    // bytes that end no frame never wait on the output side
    assign consume  = in_valid_reg && (!eng_out.last || out_free);
    assign s_tready = !in_valid_reg || consume;

    msrp_frame_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (consume),
        .rx_byte        (in_byte_reg),
        .frame_start    (in_start_reg),
        .device_address (dev_addr_reg),
        .function_code  (func_code_reg),
        .eng_out        (eng_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= RESET_DEVICE_ADDRESS;
            func_code_reg <= RESET_FUNCTION_CODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: dev_addr_reg  <= cfg_wdata;
                REG_FUNCTION_CODE:  func_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (consume)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (consume && eng_out.last)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (consume && eng_out.last)
            out_data_reg <= eng_out.result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

endmodule

[rtl/msrp_checker.sv]
// port-level checks on the modbus response parser, bound to the top level
`timescale 1ns / 1ps
`include "modbus_sensor_response_parser_macros.svh"

module msrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    import msrp_pkg::*;

    logic bad_word;
    logic stalled;

    assign bad_word = m_tvalid && (m_tdata[1:0] != STATUS_OK);
    assign stalled  = m_tvalid && !m_tready;

    // a failed check carries no readings
    `MSRP_ASSERT_SAME(a_bad_status_zero, clk, rst_n, bad_word, m_tdata[33:2] == 32'd0)
    // readings are scaled by ten, so always even
    `MSRP_ASSERT_SAME(a_scaled_even, clk, rst_n, m_tvalid, !m_tdata[2] && !m_tdata[18])
    // with nothing waiting at the output the input side is never blocked
    `MSRP_ASSERT_SAME(a_ready_when_idle, clk, rst_n, !m_tvalid, s_tready)
    // a stalled word holds
    `MSRP_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled, m_tvalid && $stable(m_tdata))

endmodule

bind modbus_sensor_response_parser msrp_checker u_msrp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
